// ===== rtl/stq_pkg.sv =====
package stq_pkg;

   localparam int ID_BITS = 4;
   localparam int TAG_BITS = 16;
   localparam int IN_TIME_BITS = 32;
   localparam int MAX_SLOTS = 16;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_ADJUST = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_TICK   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_EXPIRED  = 2'd1,
      ST_UNKNOWN  = 2'd2,
      ST_DUPLICATE = 2'd3
   } status_type;

endpackage

// ===== rtl/stq_store.sv =====
module stq_store
   import stq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int TIME_BITS = 32,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 exp_we,
   input  logic [AW-1:0]        exp_waddr,
   input  logic [TIME_BITS-1:0] exp_wdata,
   input  logic [AW-1:0]        exp_raddr,
   output logic [TIME_BITS-1:0] exp_rdata,
   input  logic                 tag_we,
   input  logic [AW-1:0]        tag_waddr,
   input  logic [TAG_BITS-1:0]  tag_wdata,
   input  logic [AW-1:0]        tag_raddr,
   output logic [TAG_BITS-1:0]  tag_rdata
);

   logic [TIME_BITS-1:0] exp_mem [DEPTH];
   logic [TAG_BITS-1:0]  tag_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (exp_we) begin
         exp_mem[exp_waddr] <= exp_wdata;
      end
      exp_rdata <= exp_mem[exp_raddr];
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_waddr] <= tag_wdata;
      end
      tag_rdata <= tag_mem[tag_raddr];
   end

endmodule

// ===== rtl/sorted_timer_queue.sv =====
// Sorted timer queue. Up to the lower of DEPTH and sixteen timers are kept in
// ascending expiry order, equal expiries first-in first-out. Start is taken
// when busy is low. Add, adjust and delete give one result; a tick gives one
// expired item per timer due, in order, and a closing item with last set.
// Results appear for one cycle under rsp_valid and cannot be stalled. An add
// walks the order list, reading the expiry of each entry and comparing it
// once the read returns, until it finds the insertion point. An adjust first
// searches the list at one entry per cycle and then walks it like an add.
// A delete searches the list like an adjust and then unlinks the entry; a
// tick reads, compares and pops the head per expired timer, and an error is
// answered straight from idle. Expiry and tag live in memories with a
// registered read; the order list is a shift register row.
module sorted_timer_queue
   import stq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int TIME_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_action,
   input  logic [ID_BITS-1:0]      req_timer_id,
   input  logic [IN_TIME_BITS-1:0] req_expire_time,
   input  logic [TAG_BITS-1:0]     req_user_tag,
   input  logic [IN_TIME_BITS-1:0] req_current_time,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [ID_BITS-1:0]      rsp_timer_id_res,
   output logic [TAG_BITS-1:0]     rsp_expired_tag,
   output logic                    rsp_last
);

   localparam int NSLOT = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(NSLOT + 1);
   localparam int PW = (NSLOT > 1) ? $clog2(NSLOT) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_FIND, S_SCAN, S_INSERT, S_TICK_RD, S_TICK_CMP, S_TICK_WAIT
   } state_type;

   state_type                state_ff;
   logic [NSLOT-1:0]         active_ff;
   logic [CW-1:0]            count_ff;
   logic [ID_BITS-1:0]       order_ff [NSLOT];
   logic [1:0]               act_ff;
   logic [ID_BITS-1:0]       id_ff;
   logic [TIME_BITS-1:0]     exp_ff;
   logic [TIME_BITS-1:0]     now_ff;
   logic [CW-1:0]            pos_ff;
   logic                     rd_pend_ff;
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic [ID_BITS-1:0]       rsp_id_ff;
   logic [TAG_BITS-1:0]      rsp_tag_ff;
   logic                     rsp_last_ff;

   logic                     exp_we;
   logic [AW-1:0]            exp_waddr;
   logic [AW-1:0]            exp_raddr;
   logic [TIME_BITS-1:0]     exp_rdata;
   logic                     tag_we;
   logic [AW-1:0]            tag_raddr;
   logic [TAG_BITS-1:0]      tag_rdata;
   logic [ID_BITS-1:0]       rd_id;
   logic                     id_ok;

   stq_store #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS), .AW(AW)) u_store (
      .clock     (clock),
      .exp_we    (exp_we),
      .exp_waddr (exp_waddr),
      .exp_wdata (TIME_BITS'(req_expire_time)),
      .exp_raddr (exp_raddr),
      .exp_rdata (exp_rdata),
      .tag_we    (tag_we),
      .tag_waddr (exp_waddr),
      .tag_wdata (req_user_tag),
      .tag_raddr (tag_raddr),
      .tag_rdata (tag_rdata)
   );

   // Expiry, and for an add also the tag, is written at acceptance; the walk reads other entries.
   always_comb begin
      id_ok = ({{(32-ID_BITS){1'b0}}, req_timer_id} < NSLOT);
      exp_we = 1'b0;
      tag_we = 1'b0;
      if (state_ff == S_IDLE && start && id_ok) begin
         if (req_action == ACT_ADD && !active_ff[req_timer_id[PW-1:0]]) begin
            exp_we = 1'b1;
            tag_we = 1'b1;
         end
         if (req_action == ACT_ADJUST && active_ff[req_timer_id[PW-1:0]]) begin
            exp_we = 1'b1;
         end
      end
      exp_waddr = AW'(req_timer_id);
      if (state_ff == S_SCAN) begin
         rd_id = order_ff[pos_ff[PW-1:0]];
      end else begin
         rd_id = order_ff[0];
      end
      exp_raddr = AW'(rd_id);
      tag_raddr = AW'(order_ff[0]);
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_timer_id_res = rsp_id_ff;
   assign rsp_expired_tag = rsp_tag_ff;
   assign rsp_last = rsp_last_ff;

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         active_ff <= '0;
         count_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  act_ff <= req_action;
                  id_ff <= req_timer_id;
                  exp_ff <= TIME_BITS'(req_expire_time);
                  now_ff <= TIME_BITS'(req_current_time);
                  pos_ff <= '0;
                  rsp_id_ff <= req_timer_id;
                  rsp_tag_ff <= '0;
                  rsp_last_ff <= 1'b1;
                  if (req_action == ACT_TICK) begin
                     state_ff <= S_TICK_RD;
                  end else if (!id_ok) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_status_ff <= ST_UNKNOWN;
                  end else if (req_action == ACT_ADD) begin
                     if (active_ff[req_timer_id[PW-1:0]]) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_status_ff <= ST_DUPLICATE;
                     end else begin
                        active_ff[req_timer_id[PW-1:0]] <= 1'b1;
                        rd_pend_ff <= 1'b0;
                        state_ff <= S_SCAN;
                     end
                  end else if (!active_ff[req_timer_id[PW-1:0]]) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_status_ff <= ST_UNKNOWN;
                  end else begin
                     if (req_action == ACT_DELETE) begin
                        active_ff[req_timer_id[PW-1:0]] <= 1'b0;
                     end
                     state_ff <= S_FIND;
                  end
               end
            end
            S_FIND: begin
               // Unlink: shift the tail up over the matching entry.
               if (order_ff[pos_ff[PW-1:0]] == id_ff) begin
                  for (int j = 0; j < NSLOT - 1; j++) begin
                     if (CW'(j) >= pos_ff) begin
                        order_ff[j] <= order_ff[j+1];
                     end
                  end
                  count_ff <= count_ff - 1'b1;
                  pos_ff <= '0;
                  rd_pend_ff <= 1'b0;
                  if (act_ff == ACT_DELETE) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_status_ff <= ST_DONE;
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end else begin
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            S_SCAN: begin
               // Expiry reads alternate with compares: rd_pend_ff marks a read in flight,
               // and the registered read data is compared before the next read starts.
               if (!rd_pend_ff) begin
                  if (pos_ff >= count_ff) begin
                     state_ff <= S_INSERT;
                  end else begin
                     rd_pend_ff <= 1'b1;
                  end
               end else begin
                  rd_pend_ff <= 1'b0;
                  if (exp_rdata <= exp_ff) begin
                     pos_ff <= pos_ff + 1'b1;
                  end else begin
                     state_ff <= S_INSERT;
                  end
               end
            end
            S_INSERT: begin
               for (int j = 1; j < NSLOT; j++) begin
                  if (CW'(j) > pos_ff) begin
                     order_ff[j] <= order_ff[j-1];
                  end
               end
               order_ff[pos_ff[PW-1:0]] <= id_ff;
               count_ff <= count_ff + 1'b1;
               rsp_valid_ff <= 1'b1;
               rsp_status_ff <= ST_DONE;
               state_ff <= S_IDLE;
            end
            S_TICK_RD: begin
               if (count_ff == '0) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= ST_DONE;
                  rsp_id_ff <= '0;
                  rsp_tag_ff <= '0;
                  rsp_last_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_TICK_CMP;
               end
            end
            S_TICK_CMP: begin
               if (now_ff < exp_rdata) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= ST_DONE;
                  rsp_id_ff <= '0;
                  rsp_tag_ff <= '0;
                  rsp_last_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= ST_EXPIRED;
                  rsp_id_ff <= order_ff[0];
                  rsp_tag_ff <= tag_rdata;
                  rsp_last_ff <= 1'b0;
                  active_ff[order_ff[0][PW-1:0]] <= 1'b0;
                  for (int j = 0; j < NSLOT - 1; j++) begin
                     order_ff[j] <= order_ff[j+1];
                  end
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_TICK_WAIT;
               end
            end
            S_TICK_WAIT: begin
               state_ff <= S_TICK_RD;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== verif/tb_sorted_timer_queue.sv =====
`timescale 1ns / 100ps

module tb_sorted_timer_queue;
   import stq_pkg::*;

   localparam int NSLOT = 16;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  timer_id;
      logic [15:0] tag;
      logic        last;
   } timer_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = ACT_TICK;
   logic [3:0]  req_timer_id = '0;
   logic [31:0] req_expire_time = '0;
   logic [15:0] req_user_tag = '0;
   logic [31:0] req_current_time = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_timer_id_res;
   logic [15:0] rsp_expired_tag;
   logic        rsp_last;

   logic [31:0] slot_expiry[NSLOT];
   logic [15:0] slot_tag[NSLOT];
   logic [15:0] slot_active;
   logic [3:0]  queue_order[$];
   timer_event_type pending_events[$];
   int          mismatch_count = 0;
   int          event_count = 0;
   bit          idle_enable = 1'b1;

   sorted_timer_queue uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_timer_id(req_timer_id),
      .req_expire_time(req_expire_time), .req_user_tag(req_user_tag),
      .req_current_time(req_current_time), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_timer_id_res(rsp_timer_id_res),
      .rsp_expired_tag(rsp_expired_tag), .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   function automatic timer_event_type make_event(logic [1:0] st, logic [3:0] id,
                                                  logic [15:0] tg, logic lst);
      timer_event_type ev;
      ev.status = st;
      ev.timer_id = id;
      ev.tag = tg;
      ev.last = lst;
      return ev;
   endfunction

   task automatic sort_in(logic [3:0] id);
      int pos;
      pos = 0;
      while (pos < queue_order.size() && slot_expiry[queue_order[pos]] <= slot_expiry[id])
         pos++;
      queue_order.insert(pos, id);
   endtask

   task automatic take_out(logic [3:0] id);
      foreach (queue_order[i]) begin
         if (queue_order[i] == id) begin
            queue_order.delete(i);
            return;
         end
      end
   endtask

   task automatic predict_timer_events(logic [1:0] act, logic [3:0] id, logic [31:0] exp_t,
                                       logic [15:0] tg, logic [31:0] now);
      logic [3:0] head;
      if (act == ACT_TICK) begin
         while (queue_order.size() > 0 && now >= slot_expiry[queue_order[0]]) begin
            head = queue_order.pop_front();
            pending_events.push_back(make_event(ST_EXPIRED, head, slot_tag[head], 1'b0));
            slot_active[head] = 1'b0;
         end
         pending_events.push_back(make_event(ST_DONE, 4'd0, 16'd0, 1'b1));
      end else if (act == ACT_ADD) begin
         if (slot_active[id]) begin
            pending_events.push_back(make_event(ST_DUPLICATE, id, 16'd0, 1'b1));
         end else begin
            slot_expiry[id] = exp_t;
            slot_tag[id] = tg;
            slot_active[id] = 1'b1;
            sort_in(id);
            pending_events.push_back(make_event(ST_DONE, id, 16'd0, 1'b1));
         end
      end else if (!slot_active[id]) begin
         pending_events.push_back(make_event(ST_UNKNOWN, id, 16'd0, 1'b1));
      end else begin
         take_out(id);
         if (act == ACT_ADJUST) begin
            slot_expiry[id] = exp_t;
            sort_in(id);
         end else begin
            slot_active[id] = 1'b0;
         end
         pending_events.push_back(make_event(ST_DONE, id, 16'd0, 1'b1));
      end
   endtask

   task automatic send_item(logic [1:0] act, logic [3:0] id, logic [31:0] exp_t,
                            logic [15:0] tg, logic [31:0] now);
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < 29) @(negedge clock);
      start <= 1'b1;
      req_action <= act;
      req_timer_id <= id;
      req_expire_time <= exp_t;
      req_user_tag <= tg;
      req_current_time <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_timer_events(act, id, exp_t, tg, now);
      @(negedge clock);
      start <= 1'b0;
   endtask

   always @(posedge clock) begin
      timer_event_type got, want;
      if (!reset && rsp_valid) begin
         got = make_event(rsp_status, rsp_timer_id_res, rsp_expired_tag, rsp_last);
         if (pending_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: status %0d id %0d tag %h last %0d",
                        got.status, got.timer_id, got.tag, got.last);
         end else begin
            want = pending_events.pop_front();
            event_count++;
            if (got != want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result %0d: expected st %0d id %0d tag %h last %0d",
                           event_count, want.status, want.timer_id, want.tag, want.last);
                  $display("result %0d: got st %0d id %0d tag %h last %0d",
                           event_count, got.status, got.timer_id, got.tag, got.last);
               end
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_events.size() > 0) @(negedge clock);
   endtask

   task automatic test_errors();
      send_item(ACT_ADJUST, 4'd3, 32'd5, 16'd0, 32'd0);
      send_item(ACT_DELETE, 4'd15, 32'd0, 16'd0, 32'd0);
      send_item(ACT_TICK, 4'd0, 32'd0, 16'd0, 32'd0);
      send_item(ACT_ADD, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
      send_item(ACT_ADD, 4'd15, 32'd1, 16'd1, 32'd0);
      send_item(ACT_TICK, 4'd0, 32'd0, 16'd0, 32'hFFFF_FFFE);
      send_item(ACT_TICK, 4'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
   endtask

   task automatic test_ordering();
      send_item(ACT_ADD, 4'd0, 32'd100, 16'hA000, 32'd0);
      send_item(ACT_ADD, 4'd1, 32'd100, 16'hA001, 32'd0);
      send_item(ACT_ADD, 4'd2, 32'd50, 16'hA002, 32'd0);
      send_item(ACT_ADD, 4'd3, 32'd0, 16'h0000, 32'd0);
      send_item(ACT_ADJUST, 4'd0, 32'd100, 16'd0, 32'd0);
      send_item(ACT_ADJUST, 4'd1, 32'd10, 16'd0, 32'd0);
      send_item(ACT_ADJUST, 4'd2, 32'd200, 16'd0, 32'd0);
      send_item(ACT_DELETE, 4'd3, 32'd0, 16'd0, 32'd0);
      send_item(ACT_TICK, 4'd0, 32'd0, 16'd0, 32'd9);
      send_item(ACT_TICK, 4'd0, 32'd0, 16'd0, 32'd100);
      send_item(ACT_TICK, 4'd0, 32'd0, 16'd0, 32'd200);
   endtask

   task automatic test_full_queue();
      for (int i = 0; i < NSLOT; i++)
         send_item(ACT_ADD, 4'(i), 32'($urandom_range(3)), 16'($urandom), 32'd0);
      send_item(ACT_TICK, 4'd0, 32'd0, 16'd0, 32'd3);
      wait_drained();
   endtask

   task automatic test_random(int count);
      logic [1:0] act;
      logic [31:0] base;
      base = 32'd0;
      for (int n = 0; n < count; n++) begin
         idle_enable = !(n >= 40 && n < 70);
         act = 2'($urandom_range(3));
         if ($urandom_range(9) < 6 && act == ACT_TICK) act = ACT_ADD;
         if (act == ACT_TICK) begin
            base = base + $urandom_range(40);
            send_item(act, 4'($urandom), $urandom, 16'($urandom),
                      ($urandom_range(19) == 0) ? $urandom : base);
         end else begin
            send_item(act, 4'($urandom), ($urandom_range(9) == 0) ? $urandom
                      : base + $urandom_range(60), 16'($urandom), $urandom);
         end
         if (n == count / 2) wait_drained();
      end
      idle_enable = 1'b1;
      send_item(ACT_TICK, 4'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
   endtask

   initial begin
      slot_active = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_errors();
      test_ordering();
      test_full_queue();
      test_random(85);
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_events.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
